// File: rtl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the PostScript line escaper
// Character codes, body kinds, the decoded item descriptor and the closing
// text of a show line.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_SUBST  = 8'hB7;

  // Tab stop spacing and closing text length
  localparam int unsigned TAB_STOP = 8;
  localparam int unsigned TAIL_LEN = 5;

  localparam int unsigned COL_W  = $clog2(TAB_STOP);
  localparam int unsigned LEN_W  = $clog2(TAB_STOP + 1);
  localparam int unsigned TAIL_W = $clog2(TAIL_LEN);

  // Body kinds of one decoded item
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TAB  = 2'd1;
  localparam logic [1:0] KIND_ESC  = 2'd2;
  localparam logic [1:0] KIND_CHAR = 2'd3;

  // Decoded item: what the emitter sends for it, in order
  typedef struct packed {
    logic             open;  // leading "("
    logic [1:0]       kind;  // body kind
    logic [LEN_W-1:0] len;   // body byte count
    logic [7:0]       ch;    // shown character
    logic             tail;  // closing ") LS\n"
  } ple_desc_t;

  // Bytes of the closing text ") LS\n"
  function automatic logic [7:0] tail_byte(input logic [TAIL_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CH_RPAREN;
      3'd1:    b = CH_SPACE;
      3'd2:    b = 8'h4C;
      3'd3:    b = 8'h53;
      3'd4:    b = 8'h0A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/ple_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_if: item channels of the PostScript line escaper
// Valid/ready channels for input bytes and for emitted PostScript bytes.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, char_byte, line_end, input ready);
  modport sink   (input valid, char_byte, line_end, output ready);
endinterface

interface ple_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: rtl/postscript_line_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postscript_line_escaper: text line to PostScript show line
// Escapes and expands one byte per item into the bytes of a "(...) LS" line.
// ----------------------------------------------------------------------------
// The first output byte of an item passes the descriptor register, then the output register.
// One output byte per cycle while the receiver takes bytes; an item yields 1 to
//   14 bytes in the byte sequencer, and items with no bytes take no slot there.
// A new item is accepted only once the descriptor register is empty or retires.
// Reset (synchronous, rst_n low) returns to line start and drops all items.
module postscript_line_escaper
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  logic      desc_valid;
  ple_desc_t desc;
  logic      desc_pop;

  ple_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_char    (in_ch.char_byte),
    .in_end     (in_ch.line_end),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_pop   (desc_pop)
  );

  ple_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_pop   (desc_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.last)
  );

endmodule

// File: rtl/ple_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_decode: line state and item decode
// Tracks line start, form feed skip, end of text and the tab column, and
// turns each accepted byte into a registered descriptor for the emitter.
// ----------------------------------------------------------------------------
module ple_decode
  import ple_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end,
  output logic       desc_valid,
  output ple_desc_t  desc,
  input  logic       desc_pop
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             at_start_r, at_start_nxt;
  logic             skip_r, skip_nxt;
  logic             ended_r, ended_nxt;
  logic             desc_valid_r;
  ple_desc_t        desc_r, desc_nxt;
  logic             accept;
  logic             is_ff_first;
  logic             skipping;
  logic             has_results;
  logic [7:0]       shown;

  assign in_ready   = !desc_valid_r || desc_pop;
  assign accept     = in_valid && in_ready;
  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

  // Decode one byte against the current line state
  always_comb begin
    is_ff_first  = at_start_r && (in_char == CH_FF);
    skipping     = skip_r || is_ff_first;
    shown        = ((in_char < CH_SPACE) || (in_char > CH_DEL)) ? CH_SUBST : in_char;

    col_nxt      = col_r;
    at_start_nxt = 1'b0;
    skip_nxt     = skipping;
    ended_nxt    = ended_r;

    desc_nxt.open = at_start_r && !is_ff_first;
    desc_nxt.kind = KIND_NONE;
    desc_nxt.len  = '0;
    desc_nxt.ch   = shown;
    desc_nxt.tail = in_end && !skipping;

    if (!skipping && !ended_r) begin
      if (in_char == CH_NUL) begin
        ended_nxt = 1'b1;
      end else if (in_char == CH_TAB) begin
        desc_nxt.kind = KIND_TAB;
        desc_nxt.len  = LEN_W'(TAB_STOP) - LEN_W'(col_r);
        col_nxt       = '0;
      end else if ((shown == CH_LPAREN) || (shown == CH_RPAREN) ||
                   (shown == CH_BSLASH)) begin
        desc_nxt.kind = KIND_ESC;
        desc_nxt.len  = LEN_W'(2);
        col_nxt       = col_r + COL_W'(1);
      end else begin
        desc_nxt.kind = KIND_CHAR;
        desc_nxt.len  = LEN_W'(1);
        col_nxt       = col_r + COL_W'(1);
      end
    end

    // End of line returns to the start-of-line state
    if (in_end) begin
      col_nxt      = '0;
      at_start_nxt = 1'b1;
      skip_nxt     = 1'b0;
      ended_nxt    = 1'b0;
    end

    has_results = desc_nxt.open || (desc_nxt.len != '0) || desc_nxt.tail;
  end

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      at_start_r <= 1'b1;
      skip_r     <= 1'b0;
      ended_r    <= 1'b0;
    end else if (accept) begin
      col_r      <= col_nxt;
      at_start_r <= at_start_nxt;
      skip_r     <= skip_nxt;
      ended_r    <= ended_nxt;
    end
  end

  // Descriptor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
    end else if (accept) begin
      desc_valid_r <= has_results;
    end else if (desc_pop) begin
      desc_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

// File: rtl/ple_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_emit: byte sequencer and output register
// Walks one descriptor through its opening, body and closing bytes, one
// byte per cycle while the output is free or taken, into a registered output stage.
// ----------------------------------------------------------------------------
module ple_emit
  import ple_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       desc_valid,
  input  ple_desc_t  desc,
  output logic       desc_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic              open_done_r;
  logic [LEN_W-1:0]  body_cnt_r;
  logic [TAIL_W-1:0] tail_cnt_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              beat;
  logic              is_open;
  logic              is_body;
  logic              is_last;
  logic [7:0]        byte_nxt;

  assign beat      = desc_valid && (!out_valid_r || out_ready);
  assign desc_pop  = beat && is_last;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Pick the current byte of the descriptor
  always_comb begin
    is_open = desc.open && !open_done_r;
    is_body = !is_open && (body_cnt_r != desc.len);
    if (is_open) begin
      byte_nxt = CH_LPAREN;
      is_last  = (desc.len == '0) && !desc.tail;
    end else if (is_body) begin
      unique case (desc.kind)
        KIND_TAB:  byte_nxt = CH_SPACE;
        KIND_ESC:  byte_nxt = (body_cnt_r == '0) ? CH_BSLASH : desc.ch;
        KIND_CHAR: byte_nxt = desc.ch;
        default:   byte_nxt = desc.ch;
      endcase
      is_last = ((body_cnt_r + LEN_W'(1)) == desc.len) && !desc.tail;
    end else begin
      byte_nxt = tail_byte(tail_cnt_r);
      is_last  = (tail_cnt_r == TAIL_W'(TAIL_LEN - 1));
    end
  end

  // Position within the current descriptor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_done_r <= 1'b0;
      body_cnt_r  <= '0;
      tail_cnt_r  <= '0;
    end else if (beat) begin
      if (is_last) begin
        open_done_r <= 1'b0;
        body_cnt_r  <= '0;
        tail_cnt_r  <= '0;
      end else if (is_open) begin
        open_done_r <= 1'b1;
      end else if (is_body) begin
        body_cnt_r <= body_cnt_r + LEN_W'(1);
      end else begin
        tail_cnt_r <= tail_cnt_r + TAIL_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      out_byte_r <= byte_nxt;
      out_last_r <= is_last;
    end
  end

  // Body counter never runs past the body length
  a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid |-> (body_cnt_r <= desc.len))
    else $error("body counter past body length");

  // Closing text starts only after the whole body
  a_tail_order: assert property (@(posedge clk) disable iff (!rst_n)
    (desc_valid && (tail_cnt_r != '0)) |-> (body_cnt_r == desc.len))
    else $error("closing text started before body done");

  // Finishing a descriptor leaves the sequencer at its start
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    desc_pop |=> (!open_done_r && (body_cnt_r == '0) && (tail_cnt_r == '0)))
    else $error("sequencer not cleared after descriptor");

  // A byte marked last is the one that retired its descriptor
  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    beat |=> (out_last_r == $past(desc_pop)))
    else $error("last flag does not match descriptor end");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the PostScript line escaper
// Drives lines of raw bytes, one byte per item, and compares every emitted
// PostScript byte with an in-bench escaper that tracks the tab column, the
// form feed line skip and the zero byte cut-off. Both sides idle at random;
// the receiver also stalls for a long stretch, and the sender once waits for
// the output to run dry.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 170;
  localparam int unsigned HOLD_AT      = 60;     // items sent before long stall
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_AT     = 120;    // queued items before the pause
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [39:0] CLOSE_TXT    = ") LS\n";

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       drain;   // wait for an empty output before offering
  } line_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } ps_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Locally held drive values, known from time zero
  logic       drv_valid = 1'b0;
  logic [7:0] drv_char  = 8'h00;
  logic       drv_eol   = 1'b0;
  logic       rx_ready  = 1'b0;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.char_byte = drv_char;
  assign in_ch.line_end  = drv_eol;
  assign out_ch.ready    = rx_ready;

  postscript_line_escaper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  line_item_t  line_items_q[$];
  ps_byte_t    show_bytes_q[$];
  line_item_t  nxt_item;
  ps_byte_t    got_exp;
  int unsigned cycle_cnt  = 0;
  int unsigned sent_cnt   = 0;
  int unsigned mismatches = 0;
  int          tx_gap     = 0;
  int          rx_gap     = 0;
  int          hold_left  = 0;
  logic        hold_done  = 1'b0;

  // Escaper state
  logic [2:0] col_mod8;
  logic       at_start;
  logic       ff_line;
  logic       nul_seen;

  task automatic restart_line();
    col_mod8 = '0;
    at_start = 1'b1;
    ff_line  = 1'b0;
    nul_seen = 1'b0;
  endtask

  // Expected PostScript bytes for one accepted raw byte
  task automatic escape_byte(input logic [7:0] c_in, input logic eol);
    logic [7:0] c;
    ps_byte_t   res[$];
    int         spaces;
    c = c_in;
    if (at_start) begin
      at_start = 1'b0;
      if (c == CH_FF) ff_line = 1'b1;
      else res.push_back('{b: CH_LPAREN, last: 1'b0});
    end
    if (ff_line) begin
      // whole line suppressed
      if (eol) restart_line();
    end else begin
      if (!nul_seen) begin
        if (c == CH_NUL) begin
          nul_seen = 1'b1;
        end else if (c == CH_TAB) begin
          spaces = TAB_STOP - col_mod8;
          repeat (spaces) res.push_back('{b: CH_SPACE, last: 1'b0});
          col_mod8 = '0;
        end else begin
          if (c < CH_SPACE || c > CH_DEL) c = CH_SUBST;
          if (c == CH_LPAREN || c == CH_RPAREN || c == CH_BSLASH)
            res.push_back('{b: CH_BSLASH, last: 1'b0});
          res.push_back('{b: c, last: 1'b0});
          col_mod8 = col_mod8 + 3'd1;
        end
      end
      if (eol) begin
        for (int i = 0; i < 5; i++)
          res.push_back('{b: CLOSE_TXT[8*(4-i) +: 8], last: 1'b0});
        restart_line();
      end
    end
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) show_bytes_q.push_back(res[i]);
  endtask

  // Idle length: mostly none or short, a few long, none in calm windows
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_cnt % 1500) < 200) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit count_mismatch();
    mismatches++;
    return mismatches <= 10;
  endfunction

  task automatic add_item(input logic [7:0] ch, input logic eol,
                          input logic drain = 1'b0);
    line_items_q.push_back('{ch: ch, eol: eol, drain: drain});
  endtask

  // One line of random content; sometimes long, sometimes form fed
  task automatic add_random_line(input logic drain);
    int         len;
    int         r;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (k == 0 && r < 10) b = CH_FF;
      else if (r < 45) b = 8'($urandom_range(8'h21, 8'h7E));
      else if (r < 55) b = CH_SPACE;
      else if (r < 65) b = CH_TAB;
      else if (r < 75) begin
        case ($urandom_range(0, 2))
          0:       b = CH_LPAREN;
          1:       b = CH_RPAREN;
          default: b = CH_BSLASH;
        endcase
      end
      else if (r < 79) b = CH_NUL;
      else if (r < 82) b = CH_DEL;
      else b = 8'($urandom_range(0, 255));
      add_item(b, k == len - 1, drain && k == 0);
    end
  endtask

  // Driver: offer queued items, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      drv_char  <= 8'h00;
      drv_eol   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        escape_byte(in_ch.char_byte, in_ch.line_end);
        sent_cnt++;
        tx_gap = pick_gap();
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          drv_valid <= 1'b0;
        end else if (line_items_q.size() != 0 &&
                     !(line_items_q[0].drain && show_bytes_q.size() != 0)) begin
          nxt_item = line_items_q.pop_front();
          drv_valid <= 1'b1;
          drv_char  <= nxt_item.ch;
          drv_eol   <= nxt_item.eol;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check emitted bytes, pace ready
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (show_bytes_q.size() == 0) begin
          if (count_mismatch())
            $display("%0t: unexpected byte %02h last %0b", $realtime,
                     out_ch.out_byte, out_ch.last);
        end else begin
          got_exp = show_bytes_q.pop_front();
          if (got_exp.b !== out_ch.out_byte || got_exp.last !== out_ch.last) begin
            if (count_mismatch())
              $display("%0t: byte exp %02h last %0b, got %02h last %0b", $realtime,
                       got_exp.b, got_exp.last, out_ch.out_byte, out_ch.last);
          end
        end
      end
      // long stall once, else random idling
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rx_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rx_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_gap = pick_gap();
        rx_ready <= (rx_gap == 0);
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    logic        drain_set;
    restart_line();

    // Directed: escapes, substitution, DEL, then a tab at column 2
    add_item("a", 1'b0);
    add_item(CH_LPAREN, 1'b0);
    add_item(CH_RPAREN, 1'b0);
    add_item(CH_BSLASH, 1'b0);
    add_item(CH_DEL, 1'b0);
    add_item(8'h01, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h1F, 1'b0);
    add_item(CH_SPACE, 1'b0);
    add_item(CH_TAB, 1'b1);
    // tab at column zero: widest expansion
    add_item(CH_TAB, 1'b1);
    // form feed first: nothing for the whole line
    add_item(CH_FF, 1'b0);
    add_item("x", 1'b0);
    add_item(CH_FF, 1'b1);
    // empty line
    add_item(CH_NUL, 1'b1);
    // zero byte mid line cuts the rest
    add_item("b", 1'b0);
    add_item(CH_NUL, 1'b0);
    add_item("c", 1'b1);
    // form feed later in the line is just a control byte
    add_item("d", 1'b0);
    add_item(CH_FF, 1'b1);
    add_item("Z", 1'b1);
    add_item(CH_FF, 1'b1);

    // Random lines, one of them held until the output runs dry
    base = line_items_q.size();
    drain_set = 1'b0;
    while (line_items_q.size() < base + RANDOM_ITEMS) begin
      if (!drain_set && line_items_q.size() >= DRAIN_AT) begin
        drain_set = 1'b1;
        add_random_line(1'b1);
      end else begin
        add_random_line(1'b0);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (line_items_q.size() != 0 || drv_valid) @(posedge clk);
    while (show_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
